### rtl/core/gbn_pkg.sv
// Shared types, codes and helpers of the go-back-N sender.
// Used by gbn_store and go_back_n_sender; depends on nothing.
package gbn_pkg;

   // Default sizes
   localparam int MAX_WINDOW_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int HOLD_LIMIT      = 50;  // messages held, queued or unacked
   localparam int SEQ_OUT_W       = 4;   // width of the seqnum field on the result beat
   localparam int SEQ_ARG_W       = 6;   // widest internal seqnum (window up to 32)

   // Input beat kinds (req_tuser)
   localparam logic [1:0] FUNC_MSG  = 2'd0;
   localparam logic [1:0] FUNC_ACK  = 2'd1;
   localparam logic [1:0] FUNC_TMO  = 2'd2;
   localparam logic [1:0] FUNC_RSVD = 2'd3;  // no operation, status beat only

   // Result beat kinds (rsp_tuser)
   localparam logic [1:0] KIND_NEW  = 2'd0;
   localparam logic [1:0] KIND_RTX  = 2'd1;
   localparam logic [1:0] KIND_STAT = 2'd2;

   // Timer actions
   localparam logic [1:0] TMR_NONE       = 2'd0;
   localparam logic [1:0] TMR_STOP       = 2'd1;
   localparam logic [1:0] TMR_START      = 2'd2;
   localparam logic [1:0] TMR_STOP_START = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CORRUPT = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;
   localparam logic [1:0] ST_OVF     = 2'd3;

   // One stored message
   typedef struct packed {
      logic        [15:0] handle;
      logic signed [12:0] sum;
   } entry_type;

   // Memory strobes from the sequencer
   typedef struct packed {
      logic q_we;
      logic q_re;
      logic s_we;
      logic s_re;
   } store_ctl_type;

   // Packet checksum: seqnum + payload sum, saturated to 13 bits signed
   function automatic logic signed [12:0] pkt_cks(input logic [SEQ_ARG_W-1:0] seq,
                                                  input logic signed [12:0] sum);
      logic signed [14:0] t;
      t = $signed({{(15-SEQ_ARG_W){1'b0}}, seq}) + $signed({{2{sum[12]}}, sum});
      if (t > 15'sd4095)
         return 13'sd4095;
      else if (t < -15'sd4096)
         return 13'sh1000;
      else
         return t[12:0];
   endfunction

endpackage

### rtl/core/gbn_store.sv
// Message queue ring and sent-packet store of the go-back-N sender.
// Two synchronous memories with registered reads; uses gbn_pkg.
module gbn_store #(
   parameter int QUEUE_DEPTH = gbn_pkg::QUEUE_DEPTH_DEF,
   parameter int SLOTS       = 2 * gbn_pkg::MAX_WINDOW_DEF
) (
   input  logic                       clock,
   input  gbn_pkg::store_ctl_type     ctl,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] q_waddr,
   input  gbn_pkg::entry_type         q_wdata,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] q_raddr,
   output gbn_pkg::entry_type         q_rdata,
   input  logic [$clog2(SLOTS)-1:0]   s_waddr,
   input  gbn_pkg::entry_type         s_wdata,
   input  logic [$clog2(SLOTS)-1:0]   s_raddr,
   output gbn_pkg::entry_type         s_rdata
);

   gbn_pkg::entry_type queue_mem [QUEUE_DEPTH];
   gbn_pkg::entry_type sent_mem  [SLOTS];
   gbn_pkg::entry_type q_rdata_ff;
   gbn_pkg::entry_type s_rdata_ff;

   // queue ring
   always_ff @(posedge clock) begin
      if (ctl.q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      if (ctl.q_re) begin
         q_rdata_ff <= queue_mem[q_raddr];
      end
   end

   // sent packets by sequence number
   always_ff @(posedge clock) begin
      if (ctl.s_we) begin
         sent_mem[s_waddr] <= s_wdata;
      end
      if (ctl.s_re) begin
         s_rdata_ff <= sent_mem[s_raddr];
      end
   end

   assign q_rdata = q_rdata_ff;
   assign s_rdata = s_rdata_ff;

endmodule

### rtl/core/go_back_n_sender.sv
// Go-back-N sender top level: sequencer, window bookkeeping and result register.
// Depends on gbn_pkg and gbn_store.

// A message that goes out at once passes accept, queue read, packet beat and
// status beat; one that waits behind a full window or is dropped goes to status.
// A rejected ack passes accept, check and status; an accepted ack adds a loop
// step plus a queue read and packet beat per packet it releases from the queue,
// since each send waits on the queue memory's registered read. A timeout adds a
// read of the sent store and a packet beat per resent packet, then status.
// The next beat is accepted as soon as the status beat sits in the result
// register; results stall only while rsp_tready is low.
module go_back_n_sender #(
   parameter int MAX_WINDOW  = gbn_pkg::MAX_WINDOW_DEF,
   parameter int QUEUE_DEPTH = gbn_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request: tuser = func; tdata = msg_handle, msg_payload_sum, ack_number,
   // ack_seq_field, ack_payload_sum, ack_checksum (low to high), zero fill
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [111:0] req_tdata,
   // response: tuser = kind; tdata = pkt_seqnum, pkt_handle, pkt_checksum,
   // timer_action, status (low to high), zero fill; tlast = last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast,
   // send window register
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_data
);

   localparam int SLOTS  = 2 * MAX_WINDOW;
   localparam int SEQ_W  = $clog2(SLOTS);
   localparam int QA_W   = $clog2(QUEUE_DEPTH);
   localparam int UC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int HELD_W = $clog2(gbn_pkg::HOLD_LIMIT + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_ACKCHK, S_LOOP, S_QRD, S_QEMIT, S_RRD, S_REMIT, S_STATUS
   } state_type;

   // request fields
   logic        [15:0] req_handle;
   logic signed [12:0] req_msum;
   logic        [19:0] req_ack;
   logic        [19:0] req_aseq;
   logic signed [12:0] req_asum;
   logic signed [23:0] req_acks;
   assign req_handle = req_tdata[15:0];
   assign req_msum   = req_tdata[28:16];
   assign req_ack    = req_tdata[48:29];
   assign req_aseq   = req_tdata[68:49];
   assign req_asum   = req_tdata[81:69];
   assign req_acks   = req_tdata[105:82];

   state_type           state_ff, state_in;
   logic [3:0]          window_ff, window_in;
   logic [SEQ_W-1:0]    base_ff, base_in;
   logic [SEQ_W-1:0]    next_ff, next_in;
   logic [QA_W-1:0]     wp_ff, wp_in;
   logic [QA_W-1:0]     rp_ff, rp_in;
   logic [UC_W-1:0]     unsent_ff, unsent_in;
   logic [HELD_W-1:0]   held_ff, held_in;
   logic                burst_ff, burst_in;
   logic [1:0]          timer_ff, timer_in;
   logic [1:0]          status_ff, status_in;
   logic                ack_ok_ff, ack_ok_in;
   logic                ack_big_ff, ack_big_in;
   logic [SEQ_W-1:0]    ack_lo_ff, ack_lo_in;
   logic [SEQ_W-1:0]    idx_ff, idx_in;
   logic [SEQ_W-1:0]    left_ff, left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [39:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // window arithmetic
   logic [SEQ_W-1:0]    eff_w;
   logic [SEQ_W:0]      span;
   logic [SEQ_W:0]      out_diff, out_wrap;
   logic [SEQ_W-1:0]    outst;
   logic [SEQ_W:0]      off_diff, off_wrap;
   logic [SEQ_W-1:0]    off;
   logic [SEQ_W:0]      next_p1, ack_p1, idx_p1;
   logic [SEQ_W:0]      count;
   logic signed [24:0]  calc;
   logic                full;
   logic                out_free;
   logic                req_acc;
   logic                csr_acc;

   gbn_pkg::store_ctl_type ctl;
   gbn_pkg::entry_type     q_rdata;
   gbn_pkg::entry_type     s_rdata;
   gbn_pkg::entry_type     q_wdata;
   gbn_pkg::entry_type     pkt;
   logic [SEQ_W-1:0]       pkt_seq;
   logic signed [12:0]     pkt_ck;

   always_comb begin
      if (window_ff == 4'd0) begin
         eff_w = SEQ_W'(1);
      end else if (int'(window_ff) > MAX_WINDOW) begin
         eff_w = SEQ_W'(MAX_WINDOW);
      end else begin
         eff_w = SEQ_W'(window_ff);
      end
   end
   assign span = {eff_w, 1'b0};

   // packets in flight: (next - base) mod span
   assign out_diff = {1'b0, next_ff} - {1'b0, base_ff};
   assign out_wrap = out_diff + span;
   assign outst    = (next_ff >= base_ff) ? out_diff[SEQ_W-1:0] : out_wrap[SEQ_W-1:0];

   // offset of the acked number from the base
   assign off_diff = {1'b0, ack_lo_ff} - {1'b0, base_ff};
   assign off_wrap = off_diff + span;
   assign off      = (ack_lo_ff >= base_ff) ? off_diff[SEQ_W-1:0] : off_wrap[SEQ_W-1:0];
   assign count    = {1'b0, off} + (SEQ_W+1)'(1);

   assign next_p1 = {1'b0, next_ff} + (SEQ_W+1)'(1);
   assign ack_p1  = {1'b0, ack_lo_ff} + (SEQ_W+1)'(1);
   assign idx_p1  = {1'b0, idx_ff} + (SEQ_W+1)'(1);

   // ack checksum, exact
   assign calc = $signed({5'b0, req_aseq}) + $signed({5'b0, req_ack})
               + $signed({{12{req_asum[12]}}, req_asum});

   assign full = (held_ff >= HELD_W'(gbn_pkg::HOLD_LIMIT))
              || (unsent_ff >= UC_W'(QUEUE_DEPTH));

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;

   assign q_wdata.handle = req_handle;
   assign q_wdata.sum    = req_msum;

   // packet beat source and its checksum
   assign pkt     = (state_ff == S_REMIT) ? s_rdata : q_rdata;
   assign pkt_seq = (state_ff == S_REMIT) ? idx_ff : next_ff;
   assign pkt_ck  = gbn_pkg::pkt_cks(gbn_pkg::SEQ_ARG_W'(pkt_seq), pkt.sum);

   // memory strobes
   always_comb begin
      ctl.q_we = req_acc && (req_tuser == gbn_pkg::FUNC_MSG) && !full;
      ctl.q_re = (state_ff == S_QRD);
      ctl.s_we = (state_ff == S_QEMIT) && out_free;
      ctl.s_re = (state_ff == S_RRD);
   end

   gbn_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SLOTS       (SLOTS)
   ) u_store (
      .clock   (clock),
      .ctl     (ctl),
      .q_waddr (wp_ff),
      .q_wdata (q_wdata),
      .q_raddr (rp_ff),
      .q_rdata (q_rdata),
      .s_waddr (next_ff),
      .s_wdata (q_rdata),
      .s_raddr (idx_ff),
      .s_rdata (s_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      unsent_in    = unsent_ff;
      held_in      = held_ff;
      burst_in     = burst_ff;
      timer_in     = timer_ff;
      status_in    = status_ff;
      ack_ok_in    = ack_ok_ff;
      ack_big_in   = ack_big_ff;
      ack_lo_in    = ack_lo_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (csr_acc) begin
               window_in = csr_data;
               base_in   = '0;
               next_in   = '0;
               wp_in     = '0;
               rp_in     = '0;
               unsent_in = '0;
               held_in   = '0;
            end else if (req_acc) begin
               timer_in  = gbn_pkg::TMR_NONE;
               status_in = gbn_pkg::ST_OK;
               burst_in  = 1'b0;
               case (req_tuser)
                  gbn_pkg::FUNC_MSG: begin
                     if (full) begin
                        status_in = gbn_pkg::ST_OVF;
                        state_in  = S_STATUS;
                     end else begin
                        wp_in     = (int'(wp_ff) == QUEUE_DEPTH - 1) ? '0 : wp_ff + QA_W'(1);
                        unsent_in = unsent_ff + UC_W'(1);
                        held_in   = held_ff + HELD_W'(1);
                        if (outst < eff_w) begin
                           if (outst == '0) begin
                              timer_in = gbn_pkg::TMR_START;
                           end
                           state_in = S_QRD;
                        end else begin
                           state_in = S_STATUS;
                        end
                     end
                  end
                  gbn_pkg::FUNC_ACK: begin
                     ack_ok_in  = (calc == $signed({req_acks[23], req_acks}));
                     ack_big_in = (req_ack >= 20'(span));
                     ack_lo_in  = req_ack[SEQ_W-1:0];
                     state_in   = S_ACKCHK;
                  end
                  gbn_pkg::FUNC_TMO: begin
                     timer_in = gbn_pkg::TMR_START;
                     idx_in   = base_ff;
                     left_in  = outst;
                     state_in = (outst == '0) ? S_STATUS : S_RRD;
                  end
                  default: begin
                     state_in = S_STATUS;
                  end
               endcase
            end
         end
         S_ACKCHK: begin
            if (!ack_ok_ff) begin
               status_in = gbn_pkg::ST_CORRUPT;
               state_in  = S_STATUS;
            end else if (ack_big_ff || (off >= outst)) begin
               status_in = gbn_pkg::ST_RANGE;
               state_in  = S_STATUS;
            end else begin
               base_in  = (ack_p1 == span) ? '0 : ack_p1[SEQ_W-1:0];
               held_in  = (int'(held_ff) >= int'(count)) ? held_ff - HELD_W'(count) : '0;
               burst_in = 1'b1;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if ((unsent_ff != '0) && (outst < eff_w)) begin
               state_in = S_QRD;
            end else begin
               timer_in = (base_ff != next_ff) ? gbn_pkg::TMR_STOP_START : gbn_pkg::TMR_STOP;
               state_in = S_STATUS;
            end
         end
         S_QRD: begin
            state_in = S_QEMIT;
         end
         S_QEMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = gbn_pkg::KIND_NEW;
               rsp_last_in  = 1'b0;
               rsp_data_in  = {7'b0, pkt_ck, pkt.handle, gbn_pkg::SEQ_OUT_W'(pkt_seq)};
               rp_in        = (int'(rp_ff) == QUEUE_DEPTH - 1) ? '0 : rp_ff + QA_W'(1);
               unsent_in    = unsent_ff - UC_W'(1);
               next_in      = (next_p1 == span) ? '0 : next_p1[SEQ_W-1:0];
               state_in     = burst_ff ? S_LOOP : S_STATUS;
            end
         end
         S_RRD: begin
            state_in = S_REMIT;
         end
         S_REMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = gbn_pkg::KIND_RTX;
               rsp_last_in  = 1'b0;
               rsp_data_in  = {7'b0, pkt_ck, pkt.handle, gbn_pkg::SEQ_OUT_W'(pkt_seq)};
               idx_in       = (idx_p1 == span) ? '0 : idx_p1[SEQ_W-1:0];
               left_in      = left_ff - SEQ_W'(1);
               state_in     = (left_ff == SEQ_W'(1)) ? S_STATUS : S_RRD;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = gbn_pkg::KIND_STAT;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {3'b0, status_ff, timer_ff, 33'b0};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= 4'd8;
         base_ff      <= '0;
         next_ff      <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         unsent_ff    <= '0;
         held_ff      <= '0;
         burst_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         unsent_ff    <= unsent_in;
         held_ff      <= held_in;
         burst_ff     <= burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      timer_ff    <= timer_in;
      status_ff   <= status_in;
      ack_ok_ff   <= ack_ok_in;
      ack_big_ff  <= ack_big_in;
      ack_lo_ff   <= ack_lo_in;
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // queued-but-unsent messages are a subset of held ones
   a_held_covers_unsent: assert property (@(posedge clock) disable iff (reset)
      int'(unsent_ff) <= int'(held_ff))
      else $error("unsent count exceeds held count");

   // never more than a window in flight
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      outst <= eff_w)
      else $error("outstanding packets exceed the window");

   // buffer never grows past its limit
   a_held_limit: assert property (@(posedge clock) disable iff (reset)
      int'(held_ff) <= gbn_pkg::HOLD_LIMIT)
      else $error("held count past buffer limit");

   // a window write empties the sender
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      csr_acc |=> (held_ff == '0) && (unsent_ff == '0) && (base_ff == next_ff))
      else $error("config write did not clear sender state");

   // a send from the queue needs a message waiting
   a_send_has_msg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QRD) |-> (unsent_ff != '0))
      else $error("queue read with no message waiting");
`endif

endmodule
